>>> hdl/cramer_3x3_solver_defines.svh
// ----------------------------------------------------------------------------
// cramer_3x3_solver_defines
// assertion macros shared by the solver modules
// ----------------------------------------------------------------------------
`ifndef CRAMER_3X3_SOLVER_DEFINES_SVH
`define CRAMER_3X3_SOLVER_DEFINES_SVH

// condition must never hold outside reset
`define CRM_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define CRM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> hdl/crm_pkg.sv
// ----------------------------------------------------------------------------
// crm_pkg
// types and constants of the 3x3 cramer solver
// ----------------------------------------------------------------------------
package crm_pkg;

    localparam int ENTRY_W    = 16;
    localparam int FRAC_BITS  = 16;
    localparam int OUT_W      = 48;
    localparam int PROD_W     = 2 * ENTRY_W;
    localparam int MINOR_W    = PROD_W + 1;
    localparam int TERM_W     = ENTRY_W + MINOR_W - 1;
    localparam int DET_W      = TERM_W + 2;
    localparam int MAG_W      = DET_W - 1;
    localparam int DIV_STAGES = OUT_W;
    localparam int Q_DEPTH    = 8;
    localparam int QPTR_W     = $clog2(Q_DEPTH);
    localparam int QCNT_W     = $clog2(Q_DEPTH + 1);

    localparam logic [OUT_W-1:0] POS_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] NEG_MAG = {1'b1, {(OUT_W-1){1'b0}}};

    typedef struct packed {
        logic signed [ENTRY_W-1:0] m00;
        logic signed [ENTRY_W-1:0] m01;
        logic signed [ENTRY_W-1:0] m02;
        logic signed [ENTRY_W-1:0] m10;
        logic signed [ENTRY_W-1:0] m11;
        logic signed [ENTRY_W-1:0] m12;
        logic signed [ENTRY_W-1:0] m20;
        logic signed [ENTRY_W-1:0] m21;
        logic signed [ENTRY_W-1:0] m22;
        logic signed [ENTRY_W-1:0] rhs0;
        logic signed [ENTRY_W-1:0] rhs1;
        logic signed [ENTRY_W-1:0] rhs2;
    } in_item_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] x_solution;
        logic signed [OUT_W-1:0] y_solution;
        logic signed [OUT_W-1:0] z_solution;
        logic                    singular;
        logic                    saturated;
    } out_item_t;

    // classified item handed from front to back
    typedef struct packed {
        logic                       singular;
        logic [MAG_W-1:0]           d_mag;
        logic [2:0][MAG_W-1:0]      n_mag;
        logic [2:0]                 neg;
    } front_item_t;

    typedef struct packed {
        logic not_empty;
        logic full;
    } q_stat_t;

endpackage

>>> hdl/cramer_3x3_solver.sv
// ----------------------------------------------------------------------------
// cramer_3x3_solver
// 3x3 linear system solver by cramer's rule, q31.16 results
// ----------------------------------------------------------------------------
//  channel   dir   handshake              payload
//  in        in    in_valid / in_ready    in_item_t  nine entries, three rhs
//  out       out   out_valid / out_ready  out_item_t x y z, singular, saturated
//
//  one item per cycle sustained while out_ready holds; with no stall an item
//  passes 5 front stages, the queue, a load register, 48 divider stages and
//  one output register
//  reset clears all valid bits and the queue, no pass over storage
//  an output stall freezes the divider; the front keeps running into the
//  eight-entry queue, and in_ready drops once eight items are outstanding
// ----------------------------------------------------------------------------
module cramer_3x3_solver
    import crm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    // items accepted but not yet popped from the queue
    logic [QCNT_W-1:0] pending_reg;
    logic [QCNT_W-1:0] pending_next;

    logic        accept;
    logic        push;
    front_item_t push_data;
    logic        pop;
    front_item_t head;
    q_stat_t     q_stat;

    assign in_ready     = (pending_reg < QCNT_W'(Q_DEPTH));
    assign accept       = in_valid && in_ready;
    assign pending_next = pending_reg + QCNT_W'(accept) - QCNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // front: determinants and sign/magnitude split, never stalls
    crm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_data   (in_data),
        .push      (push),
        .push_data (push_data)
    );

    // queue: room guaranteed by the pending count
    crm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .stat      (q_stat)
    );

    // back: divider pipeline and output register
    crm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_stat.not_empty),
        .q_head    (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

>>> hdl/crm_front.sv
// ----------------------------------------------------------------------------
// crm_front
// determinant pipeline: minors, cofactor terms, determinants, classification
// ----------------------------------------------------------------------------
module crm_front
    import crm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  in_item_t    in_data,
    output logic        push,
    output front_item_t push_data
);

    logic [4:0] vld_reg;
    logic [4:0] vld_next;

    logic signed [ENTRY_W-1:0] r0a_reg [4];
    logic signed [ENTRY_W-1:0] r0b_reg [4];
    logic signed [PROD_W-1:0]  pp_reg [12];
    logic signed [MINOR_W-1:0] mn_reg [6];
    logic signed [TERM_W-1:0]  tm_reg [12];
    logic signed [DET_W-1:0]   det_reg [4];
    front_item_t               cls_reg;

    function automatic logic [MAG_W-1:0] mag(input logic signed [DET_W-1:0] v);
        logic signed [DET_W-1:0] a;
        a = v[DET_W-1] ? -v : v;
        return a[MAG_W-1:0];
    endfunction

    function automatic logic signed [TERM_W-1:0] mul_t(input logic signed [ENTRY_W-1:0] a,
                                                       input logic signed [MINOR_W-1:0] b);
        return TERM_W'(a) * TERM_W'(b);
    endfunction

    assign vld_next = {vld_reg[3:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // stage 1: row 0 values and the twelve products of rows 1 and 2
    always_ff @(posedge clk)
    begin
        r0a_reg[0] <= in_data.m00;
        r0a_reg[1] <= in_data.m01;
        r0a_reg[2] <= in_data.m02;
        r0a_reg[3] <= in_data.rhs0;
        pp_reg[0]  <= PROD_W'(in_data.m10) * PROD_W'(in_data.m21);
        pp_reg[1]  <= PROD_W'(in_data.m11) * PROD_W'(in_data.m20);
        pp_reg[2]  <= PROD_W'(in_data.m10) * PROD_W'(in_data.m22);
        pp_reg[3]  <= PROD_W'(in_data.m12) * PROD_W'(in_data.m20);
        pp_reg[4]  <= PROD_W'(in_data.m11) * PROD_W'(in_data.m22);
        pp_reg[5]  <= PROD_W'(in_data.m12) * PROD_W'(in_data.m21);
        pp_reg[6]  <= PROD_W'(in_data.rhs1) * PROD_W'(in_data.m22);
        pp_reg[7]  <= PROD_W'(in_data.m12) * PROD_W'(in_data.rhs2);
        pp_reg[8]  <= PROD_W'(in_data.rhs1) * PROD_W'(in_data.m21);
        pp_reg[9]  <= PROD_W'(in_data.m11) * PROD_W'(in_data.rhs2);
        pp_reg[10] <= PROD_W'(in_data.m10) * PROD_W'(in_data.rhs2);
        pp_reg[11] <= PROD_W'(in_data.rhs1) * PROD_W'(in_data.m20);
    end

    // stage 2: minors m01 m02 m12 mb2 mb1 m0b
    always_ff @(posedge clk)
    begin
        r0b_reg <= r0a_reg;
        for (int k = 0; k < 6; k++)
        begin
            mn_reg[k] <= MINOR_W'(pp_reg[2*k]) - MINOR_W'(pp_reg[2*k+1]);
        end
    end

    // stage 3: cofactor terms
    always_ff @(posedge clk)
    begin
        tm_reg[0]  <= mul_t(r0b_reg[0], mn_reg[2]);
        tm_reg[1]  <= mul_t(r0b_reg[1], mn_reg[1]);
        tm_reg[2]  <= mul_t(r0b_reg[2], mn_reg[0]);
        tm_reg[3]  <= mul_t(r0b_reg[3], mn_reg[2]);
        tm_reg[4]  <= mul_t(r0b_reg[1], mn_reg[3]);
        tm_reg[5]  <= mul_t(r0b_reg[2], mn_reg[4]);
        tm_reg[6]  <= mul_t(r0b_reg[0], mn_reg[3]);
        tm_reg[7]  <= mul_t(r0b_reg[3], mn_reg[1]);
        tm_reg[8]  <= mul_t(r0b_reg[2], mn_reg[5]);
        tm_reg[9]  <= mul_t(r0b_reg[0], mn_reg[4]);
        tm_reg[10] <= mul_t(r0b_reg[1], mn_reg[5]);
        tm_reg[11] <= mul_t(r0b_reg[3], mn_reg[0]);
    end

    // stage 4: det(a), then x, y, z numerators
    always_ff @(posedge clk)
    begin
        det_reg[0] <= DET_W'(tm_reg[0]) - DET_W'(tm_reg[1]) + DET_W'(tm_reg[2]);
        det_reg[1] <= DET_W'(tm_reg[3]) - DET_W'(tm_reg[4]) + DET_W'(tm_reg[5]);
        det_reg[2] <= DET_W'(tm_reg[6]) - DET_W'(tm_reg[7]) + DET_W'(tm_reg[8]);
        det_reg[3] <= DET_W'(tm_reg[11]) - DET_W'(tm_reg[9]) - DET_W'(tm_reg[10]);
    end

    // stage 5: classify
    always_ff @(posedge clk)
    begin
        cls_reg.singular <= (det_reg[0] == '0);
        cls_reg.d_mag    <= mag(det_reg[0]);
        for (int l = 0; l < 3; l++)
        begin
            cls_reg.n_mag[l] <= mag(det_reg[l+1]);
            cls_reg.neg[l]   <= det_reg[l+1][DET_W-1] ^ det_reg[0][DET_W-1];
        end
    end

    assign push      = vld_reg[4];
    assign push_data = cls_reg;

endmodule

>>> hdl/crm_queue.sv
// ----------------------------------------------------------------------------
// crm_queue
// short fifo between the determinant front and the divider back
// ----------------------------------------------------------------------------
`include "cramer_3x3_solver_defines.svh"

module crm_queue
    import crm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  front_item_t push_data,
    input  logic        pop,
    output front_item_t head,
    output q_stat_t     stat
);

    front_item_t       mem [Q_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = push ? QPTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign head           = mem[rd_ptr_reg];
    assign stat.not_empty = (count_reg != '0);
    assign stat.full      = (count_reg == QCNT_W'(Q_DEPTH));

    `CRM_ASSERT_NEVER(a_q_no_overflow, push && stat.full, "queue written while full")
    `CRM_ASSERT_NEVER(a_q_no_underflow, pop && !stat.not_empty, "queue read while empty")

endmodule

>>> hdl/crm_back.sv
// ----------------------------------------------------------------------------
// crm_back
// pipelined restoring divider, one quotient bit per stage, and output register
// ----------------------------------------------------------------------------
`include "cramer_3x3_solver_defines.svh"

module crm_back
    import crm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  front_item_t q_head,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data
);

    typedef struct packed {
        logic [MAG_W-1:0] rem;
        logic [OUT_W-1:0] fv;
        logic [OUT_W-1:0] q;
        logic             neg;
        logic             ovf;
    } div_lane_t;

    typedef struct packed {
        logic                 singular;
        logic [MAG_W-1:0]     d;
        div_lane_t [2:0]      lane;
    } div_stage_t;

    div_stage_t stg_reg [DIV_STAGES+1];
    logic [DIV_STAGES:0] vld_reg;
    logic [DIV_STAGES:0] vld_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    out_item_t  out_data_reg;
    logic       advance;

    function automatic div_stage_t div_load(input front_item_t f);
        div_stage_t s;
        s.singular = f.singular;
        s.d        = f.d_mag;
        for (int l = 0; l < 3; l++)
        begin
            s.lane[l].rem = f.n_mag[l] >> (OUT_W - FRAC_BITS);
            s.lane[l].fv  = OUT_W'(f.n_mag[l] << FRAC_BITS);
            s.lane[l].q   = '0;
            s.lane[l].neg = f.neg[l];
            // quotient would reach 2^OUT_W
            s.lane[l].ovf = (MAG_W'(f.n_mag[l] >> (OUT_W - FRAC_BITS)) >= f.d_mag);
        end
        return s;
    endfunction

    function automatic div_stage_t div_step(input div_stage_t s, input int bit_idx);
        div_stage_t r;
        logic [MAG_W:0] sh;
        r = s;
        for (int l = 0; l < 3; l++)
        begin
            sh = {s.lane[l].rem, s.lane[l].fv[OUT_W-1-bit_idx]};
            if (sh >= {1'b0, s.d})
            begin
                r.lane[l].rem = MAG_W'(sh - {1'b0, s.d});
                r.lane[l].q   = {s.lane[l].q[OUT_W-2:0], 1'b1};
            end
            else
            begin
                r.lane[l].rem = sh[MAG_W-1:0];
                r.lane[l].q   = {s.lane[l].q[OUT_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    function automatic out_item_t finish(input div_stage_t s);
        out_item_t o;
        logic [2:0][OUT_W-1:0] v;
        logic [2:0] sat;
        logic [OUT_W-1:0] lim;
        for (int l = 0; l < 3; l++)
        begin
            lim = s.lane[l].neg ? NEG_MAG : POS_MAX;
            sat[l] = s.lane[l].ovf || (s.lane[l].q > lim);
            if (sat[l])
            begin
                v[l] = lim;
            end
            else
            begin
                v[l] = s.lane[l].neg ? OUT_W'(-s.lane[l].q) : s.lane[l].q;
            end
        end
        if (s.singular)
        begin
            o = '0;
            o.singular = 1'b1;
        end
        else
        begin
            o.x_solution = v[0];
            o.y_solution = v[1];
            o.z_solution = v[2];
            o.singular   = 1'b0;
            o.saturated  = |sat;
        end
        return o;
    endfunction

    assign advance        = !out_valid_reg || out_ready;
    assign pop            = advance && q_valid;
    assign vld_next       = {vld_reg[DIV_STAGES-1:0], q_valid};
    assign out_valid_next = vld_reg[DIV_STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg       <= vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stg_reg[0]   <= div_load(q_head);
            out_data_reg <= finish(stg_reg[DIV_STAGES]);
        end
    end

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                stg_reg[k+1] <= div_step(stg_reg[k], k);
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `CRM_ASSERT_IMPL(a_singular_zero, out_valid && out_data.singular, out_data.x_solution == '0 && out_data.y_solution == '0 && out_data.z_solution == '0 && !out_data.saturated, "singular result not cleared")

endmodule
